// ----- hw/rtl/isd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package isd_pkg;

    localparam int unsigned AddrWidth = 32;

    localparam logic [6:0] OP_NOP     = 7'd18;
    localparam logic [6:0] OP_CPY     = 7'd19;
    localparam logic [6:0] OP_J       = 7'd33;
    localparam logic [6:0] OP_JZ      = 7'd34;
    localparam logic [6:0] OP_JNZ     = 7'd35;
    localparam logic [6:0] OP_RLI16   = 7'd37;
    localparam logic [6:0] OP_RLI32   = 7'd38;
    localparam logic [6:0] OP_DRLI    = 7'd39;
    localparam logic [6:0] OP_INC16   = 7'd40;
    localparam logic [6:0] OP_LI16    = 7'd42;
    localparam logic [6:0] OP_LI32    = 7'd43;
    localparam logic [6:0] OP_LI8     = 7'd94;
    localparam logic [6:0] OP_INC8    = 7'd95;
    localparam logic [6:0] OP_RLI8    = 7'd96;
    localparam logic [6:0] OP_PREEMPT = 7'd97;
    localparam logic [6:0] OP_UNKNOWN = 7'd98;

    localparam logic [3:0] REG_REL = 4'd13;

    localparam logic [2:0] LEN_2 = 3'd2;
    localparam logic [2:0] LEN_4 = 3'd4;
    localparam logic [2:0] LEN_6 = 3'd6;

    typedef enum logic [3:0] {
        PH_OPCODE = 4'b0001,
        PH_IMM16  = 4'b0010,
        PH_LOW    = 4'b0100,
        PH_HIGH   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0]  opcode_byte;
        logic [7:0]  operand_byte;
        logic [31:0] halfword_addr;
    } t_in_item;

    typedef struct packed {
        logic [6:0]         operation;
        logic [3:0]         reg_first;
        logic [3:0]         reg_second;
        logic [2:0]         length_bytes;
        logic signed [31:0] immediate;
        logic               has_immediate;
        logic               target_valid;
        logic [31:0]        target_addr;
    } t_out_item;

    // Operation number for an opcode byte; OP_UNKNOWN when not a fixed opcode.
    function automatic logic [6:0] op_lookup(input logic [7:0] b);
        logic [6:0] r;
        r = OP_UNKNOWN;
        case (b)
            8'hb8: r = 7'd0;  8'hb9: r = 7'd1;  8'hca: r = 7'd2;  8'hcb: r = 7'd3;
            8'hce: r = 7'd4;  8'hcf: r = 7'd5;  8'hc8: r = 7'd6;  8'hc9: r = 7'd7;
            8'hcc: r = 7'd8;  8'hcd: r = 7'd9;  8'hd8: r = 7'd10; 8'hd9: r = 7'd11;
            8'hda: r = 7'd12; 8'hdb: r = 7'd13; 8'hc3: r = 7'd14; 8'hc4: r = 7'd15;
            8'hc5: r = 7'd16; 8'hc6: r = 7'd17; 8'hc7: r = 7'd19; 8'hc0: r = 7'd20;
            8'hc1: r = 7'd21; 8'hc2: r = 7'd22; 8'hba: r = 7'd23; 8'hbb: r = 7'd24;
            8'hbc: r = 7'd25; 8'hbd: r = 7'd26; 8'hbe: r = 7'd27; 8'hbf: r = 7'd28;
            8'hb0: r = 7'd29; 8'hb1: r = 7'd30; 8'hb2: r = 7'd31; 8'hb3: r = 7'd32;
            8'hd0: r = 7'd34; 8'hd1: r = 7'd35; 8'hd2: r = 7'd36; 8'had: r = 7'd37;
            8'hae: r = 7'd38; 8'hac: r = 7'd39; 8'ha1: r = 7'd40; 8'ha2: r = 7'd41;
            8'ha9: r = 7'd42; 8'haa: r = 7'd43; 8'hf4: r = 7'd44; 8'hf5: r = 7'd45;
            8'hf6: r = 7'd46; 8'hf0: r = 7'd47; 8'hf1: r = 7'd48; 8'hf2: r = 7'd49;
            8'h74: r = 7'd50; 8'h75: r = 7'd51; 8'h76: r = 7'd52; 8'h70: r = 7'd53;
            8'h71: r = 7'd54; 8'h72: r = 7'd55; 8'hf8: r = 7'd56; 8'hf9: r = 7'd57;
            8'hfa: r = 7'd58; 8'hfc: r = 7'd59; 8'hfd: r = 7'd60; 8'hfe: r = 7'd61;
            8'h00: r = 7'd62; 8'h01: r = 7'd63; 8'h02: r = 7'd64; 8'h03: r = 7'd65;
            8'h04: r = 7'd66; 8'h05: r = 7'd67; 8'h07: r = 7'd68; 8'h39: r = 7'd69;
            8'h3c: r = 7'd70; 8'h3d: r = 7'd71; 8'h3e: r = 7'd72; 8'h3f: r = 7'd73;
            8'h38: r = 7'd74; 8'h3a: r = 7'd75; 8'h3b: r = 7'd76; 8'h79: r = 7'd77;
            8'h7a: r = 7'd78; 8'h7b: r = 7'd79; 8'h28: r = 7'd80; 8'h29: r = 7'd81;
            8'h2a: r = 7'd82; 8'h2b: r = 7'd83; 8'h2c: r = 7'd84; 8'h2d: r = 7'd85;
            8'h2e: r = 7'd86; 8'h2f: r = 7'd87; 8'h10: r = 7'd88; 8'h11: r = 7'd89;
            8'h12: r = 7'd90; 8'h13: r = 7'd91; 8'h14: r = 7'd92; 8'h15: r = 7'd93;
            default: r = OP_UNKNOWN;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/isd_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none
module isd_decode (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_step,
    input  isd_pkg::t_in_item i_item,
    output logic              o_emit,
    output isd_pkg::t_out_item o_result
);
    import isd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [6:0]  r_pend_op, n_pend_op;
    logic [7:0]  r_pend_regs, n_pend_regs;
    logic [31:0] r_pend_addr, n_pend_addr;
    logic [15:0] r_pend_low, n_pend_low;
    logic [31:0] r_last_imm, n_last_imm;

    logic [15:0] half;
    logic [6:0]  op_map;
    logic [6:0]  op;
    logic [3:0]  nib_hi;
    logic [7:0]  nib_val;
    logic        nib_form;
    logic [31:0] imm;
    logic [31:0] base_addr;
    logic [2:0]  len;
    logic [7:0]  regs;
    logic        has_imm;
    logic        rel;
    logic        jump_form;

    assign half   = {i_item.operand_byte, i_item.opcode_byte};
    assign op_map = op_lookup(i_item.opcode_byte);
    assign nib_hi = i_item.opcode_byte[7:4];
    assign nib_val = {i_item.opcode_byte[3:0], i_item.operand_byte[3:0]};
    assign nib_form = (op_map == OP_UNKNOWN) &&
                      ((nib_hi == 4'h8 && i_item.operand_byte != 8'd0) ||
                       nib_hi == 4'h9 || nib_hi == 4'he);

    always_comb begin
        n_phase     = r_phase;
        n_pend_op   = r_pend_op;
        n_pend_regs = r_pend_regs;
        n_pend_addr = r_pend_addr;
        n_pend_low  = r_pend_low;
        n_last_imm  = r_last_imm;
        o_emit      = 1'b0;
        op          = op_map;
        regs        = i_item.operand_byte;
        len         = LEN_2;
        imm         = 32'd0;
        has_imm     = 1'b0;
        base_addr   = i_item.halfword_addr;
        jump_form   = 1'b0;
        unique case (r_phase)
            PH_IMM16: begin
                o_emit = 1'b1;
                op = r_pend_op; regs = r_pend_regs; base_addr = r_pend_addr;
                len = LEN_4;
                imm = {{16{half[15]}}, half};
                has_imm = 1'b1;
                n_phase = PH_OPCODE;
            end
            PH_LOW: begin
                n_pend_low = half;
                n_phase = PH_HIGH;
            end
            PH_HIGH: begin
                o_emit = 1'b1;
                op = r_pend_op; regs = r_pend_regs; base_addr = r_pend_addr;
                len = LEN_6;
                imm = {half, r_pend_low};
                has_imm = 1'b1;
                n_phase = PH_OPCODE;
            end
            default: begin
                o_emit = 1'b1;
                if (op_map != OP_UNKNOWN) begin
                    if (op_map == OP_CPY && i_item.operand_byte == 8'd0) begin
                        op = OP_NOP;
                    end
                    if (op_map == OP_JZ || op_map == OP_JNZ) begin
                        jump_form = 1'b1;
                        if (i_item.operand_byte[7:4] == i_item.operand_byte[3:0]) begin
                            op = OP_J;
                        end
                    end else if (op_map >= OP_RLI16 && op_map <= OP_LI32) begin
                        o_emit = 1'b0;
                        n_pend_op = op_map;
                        n_pend_regs = i_item.operand_byte;
                        n_pend_addr = i_item.halfword_addr;
                        n_phase = (op_map == OP_RLI16 || op_map == OP_INC16 ||
                                   op_map == OP_LI16) ? PH_IMM16 : PH_LOW;
                    end
                end else if (nib_form) begin
                    if (nib_hi == 4'h9 && i_item.operand_byte == 8'd0 &&
                        i_item.opcode_byte[3:0] == 4'd0) begin
                        op = OP_PREEMPT;
                    end else begin
                        op = (nib_hi == 4'h8) ? OP_LI8 :
                             (nib_hi == 4'h9) ? OP_INC8 : OP_RLI8;
                        imm = {{24{nib_val[7]}}, nib_val};
                        has_imm = 1'b1;
                    end
                end
            end
        endcase
        if (i_step && o_emit && has_imm) begin
            n_last_imm = imm;
        end
        if (!i_step) begin
            n_phase = r_phase; n_pend_op = r_pend_op; n_pend_regs = r_pend_regs;
            n_pend_addr = r_pend_addr; n_pend_low = r_pend_low;
        end
    end

    assign rel = has_imm && (op == OP_RLI16 || op == OP_RLI32 || op == OP_DRLI ||
                             op == OP_RLI8);

    always_comb begin
        o_result.operation     = op;
        o_result.reg_first     = regs[7:4];
        o_result.reg_second    = regs[3:0];
        o_result.length_bytes  = len;
        o_result.immediate     = imm;
        o_result.has_immediate = has_imm;
        o_result.target_valid  = 1'b0;
        o_result.target_addr   = 32'd0;
        if (jump_form && regs[3:0] == REG_REL) begin
            o_result.target_valid = 1'b1;
            o_result.target_addr  = base_addr + r_last_imm;
        end else if (rel) begin
            o_result.target_valid = 1'b1;
            o_result.target_addr  = base_addr + {29'd0, len} + imm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OPCODE;
            r_pend_op   <= 7'd0;
            r_pend_regs <= 8'd0;
            r_pend_addr <= 32'd0;
            r_pend_low  <= 16'd0;
            r_last_imm  <= 32'd0;
        end else begin
            r_phase     <= n_phase;
            r_pend_op   <= n_pend_op;
            r_pend_regs <= n_pend_regs;
            r_pend_addr <= n_pend_addr;
            r_pend_low  <= n_pend_low;
            r_last_imm  <= n_last_imm;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_LOW) |=> r_phase == PH_HIGH)
        else $error("low half not followed by high half");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LOW) |-> !o_emit)
        else $error("result on a low immediate half");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && r_phase == PH_HIGH) |-> o_result.length_bytes == LEN_6)
        else $error("32-bit immediate form with wrong length");
endmodule
`default_nettype wire

// ----- hw/rtl/instruction_stream_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Instruction stream decoder.
// Input channel: one request per halfword (opcode byte, operand byte and the
// halfword's address) on i_in_valid / o_in_ready. Output channel: one decoded
// instruction per complete instruction on o_out_valid / i_out_ready.
// A halfword is decoded in the cycle it is accepted and the instruction is
// presented from the output register on the next cycle. Halfwords that only
// start or continue a longer instruction produce nothing.
// Throughput is one halfword per cycle unless a waiting result is stalled;
// the single output register is refilled in the same cycle it is drained.
// When the receiver stalls with a result waiting, o_in_ready stays high only
// for halfwords that produce no result, so nothing is lost.
// Reset (synchronous, active low) returns the decoder to expecting an opcode
// halfword, clears the remembered last immediate and empties the output.
module instruction_stream_decoder (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  isd_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output isd_pkg::t_out_item  o_out_data
);
    import isd_pkg::*;

    logic      step;
    logic      emit;
    logic      free;
    t_out_item result;
    logic      r_valid;
    t_out_item r_data;

    isd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (i_in_data),
        .o_emit  (emit),
        .o_result(result)
    );

    assign free       = !r_valid || i_out_ready;
    assign o_in_ready = free || !emit;
    assign step       = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (free) begin
            r_valid <= step && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (free && step && emit) begin
            r_data <= result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_out_ready) |=> r_valid)
        else $error("pending result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && emit) |=> r_valid)
        else $error("result not registered");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_out_ready) |-> !(step && emit))
        else $error("result overwritten");
endmodule
`default_nettype wire
